FILE: rtl/skyatl_pkg.sv
// ============================================================================
// Skyline atlas allocator package
// Shared widths, command codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package skyatl_pkg;

    // Default geometry, handed down from the top level.
    localparam int NUM_ATLASES_DEF  = 2;
    localparam int ATLAS_WIDTH_DEF  = 256;
    localparam int ATLAS_HEIGHT_DEF = 256;

    // Field widths of one request and one response.
    localparam int CMD_W       = 2;
    localparam int ATLAS_SEL_W = 1;
    localparam int RECT_W      = 9;
    localparam int POS_W       = 8;
    localparam int REPORT_W    = 2;

    // Stream port widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Request command codes; the fourth code is a no-operation.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DIRTY = 2'd2
    } cmd_code_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_SUF,
        ST_SUF_END,
        ST_PRE,
        ST_PRE_END,
        ST_DECIDE,
        ST_FILL,
        ST_RESP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic clr_step;
        logic suf_start;
        logic suf_step;
        logic pre_start;
        logic pre_step;
        logic fill_start;
        logic fill_step;
        logic load_result;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic             req_ok;
        logic             col_zero;
        logic             col_end;
        logic             fill_last;
        logic             clr_last;
        logic             fit;
        logic             out_free;
    } ctrl_status_t;

endpackage

FILE: rtl/skyline_atlas_allocator.sv
// ============================================================================
// Skyline atlas allocator
// Keeps a column fill skyline per texture atlas and places rectangles on it.
// ============================================================================
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the command (allocate,
//   clear all, read and clear dirty flags) and s_tdata the atlas and the
//   rectangle size. Every request gives exactly one response on the m_ channel:
//   m_tuser is the placed flag, m_tdata the position and the dirty report.
//   An allocation scans the atlas twice, one column per cycle through the
//   height memory read port: once right to left for block suffix maxima, once
//   left to right for window maxima, then writes the w covered columns. A
//   clear request sweeps the height memory one entry per cycle; a dirty,
//   unused or malformed request is answered without a scan or sweep. One
//   request is worked on at a time, and s_tready rises again in the cycle
//   after its response has been loaded. After reset the same sweep zeroes
//   the heights, with s_tready low; dirty flags clear at once.
//   A response waits in the output register while m_tready is low, and the
//   next request is still accepted; its response is held back until the
//   register is free.
// ============================================================================
module skyline_atlas_allocator #(
    parameter int NUM_ATLASES  = skyatl_pkg::NUM_ATLASES_DEF,
    parameter int ATLAS_WIDTH  = skyatl_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = skyatl_pkg::ATLAS_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // atlas_select [0], rect_width [9:1], rect_height [18:10], zero [23:19]
    input  logic [skyatl_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [skyatl_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // place_x [7:0], place_y [15:8], dirty_report [17:16], zero [23:18]
    output logic [skyatl_pkg::M_TDATA_W-1:0] m_tdata,
    // placed [0]
    output logic [skyatl_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int WIDTH_LSB  = skyatl_pkg::ATLAS_SEL_W;
    localparam int HEIGHT_LSB = WIDTH_LSB + skyatl_pkg::RECT_W;
    localparam int Y_LSB      = skyatl_pkg::POS_W;
    localparam int REP_LSB    = 2 * skyatl_pkg::POS_W;
    localparam int PAD_LSB    = REP_LSB + skyatl_pkg::REPORT_W;

    skyatl_pkg::ctrl_cmd_t    cmd;
    skyatl_pkg::ctrl_status_t sts;

    logic                            res_placed;
    logic [skyatl_pkg::POS_W-1:0]    res_x;
    logic [skyatl_pkg::POS_W-1:0]    res_y;
    logic [skyatl_pkg::REPORT_W-1:0] res_report;

    skyatl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skyatl_datapath #(
        .NUM_ATLASES  (NUM_ATLASES),
        .ATLAS_WIDTH  (ATLAS_WIDTH),
        .ATLAS_HEIGHT (ATLAS_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .req_command (s_tuser),
        .req_atlas   (s_tdata[WIDTH_LSB-1:0]),
        .req_width   (s_tdata[HEIGHT_LSB-1:WIDTH_LSB]),
        .req_height  (s_tdata[HEIGHT_LSB+skyatl_pkg::RECT_W-1:HEIGHT_LSB]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .res_placed  (res_placed),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_report  (res_report)
    );

    // Pack the response fields, lowest field first.
    assign m_tdata[Y_LSB-1:0]                = res_x;
    assign m_tdata[REP_LSB-1:Y_LSB]          = res_y;
    assign m_tdata[PAD_LSB-1:REP_LSB]        = res_report;
    assign m_tdata[skyatl_pkg::M_TDATA_W-1:PAD_LSB] = '0;
    assign m_tuser                           = res_placed;

endmodule

FILE: rtl/skyatl_ctrl.sv
// ============================================================================
// Skyline atlas allocator controller
// Sequences the clearing sweep, the two skyline scans, the column fill and
// the response hand-off.
// ============================================================================
module skyatl_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  skyatl_pkg::ctrl_status_t sts,
    output skyatl_pkg::ctrl_cmd_t    cmd
);

    skyatl_pkg::ctrl_state_t state_reg;
    skyatl_pkg::ctrl_state_t state_next;

    // State register; reset starts the clearing sweep of the height memory.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skyatl_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            skyatl_pkg::ST_INIT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = skyatl_pkg::ST_IDLE;
                end
            end
            skyatl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = skyatl_pkg::ST_DECODE;
                end
            end
            skyatl_pkg::ST_DECODE: begin
                case (sts.kind)
                    skyatl_pkg::CMD_ALLOC: begin
                        if (sts.req_ok) begin
                            cmd.suf_start = 1'b1;
                            state_next    = skyatl_pkg::ST_SUF;
                        end else begin
                            state_next = skyatl_pkg::ST_RESP;
                        end
                    end
                    skyatl_pkg::CMD_CLEAR: begin
                        state_next = skyatl_pkg::ST_CLEAR;
                    end
                    default: begin
                        state_next = skyatl_pkg::ST_RESP;
                    end
                endcase
            end
            skyatl_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = skyatl_pkg::ST_RESP;
                end
            end
            // Right-to-left scan building block suffix maxima.
            skyatl_pkg::ST_SUF: begin
                cmd.suf_step = 1'b1;
                if (sts.col_zero) begin
                    state_next = skyatl_pkg::ST_SUF_END;
                end
            end
            skyatl_pkg::ST_SUF_END: begin
                cmd.pre_start = 1'b1;
                state_next    = skyatl_pkg::ST_PRE;
            end
            // Left-to-right scan evaluating every window.
            skyatl_pkg::ST_PRE: begin
                cmd.pre_step = 1'b1;
                if (sts.col_end) begin
                    state_next = skyatl_pkg::ST_PRE_END;
                end
            end
            skyatl_pkg::ST_PRE_END: begin
                state_next = skyatl_pkg::ST_DECIDE;
            end
            skyatl_pkg::ST_DECIDE: begin
                if (sts.fit) begin
                    cmd.fill_start = 1'b1;
                    state_next     = skyatl_pkg::ST_FILL;
                end else begin
                    state_next = skyatl_pkg::ST_RESP;
                end
            end
            skyatl_pkg::ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) begin
                    state_next = skyatl_pkg::ST_RESP;
                end
            end
            skyatl_pkg::ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = skyatl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skyatl_pkg::ST_INIT;
            end
        endcase
    end

    assign s_tready = (state_reg == skyatl_pkg::ST_IDLE);

endmodule

FILE: rtl/skyatl_datapath.sv
// ============================================================================
// Skyline atlas allocator datapath
// Height memory, suffix scratch memory, scan counters, window maximum search,
// dirty flags and the response register.
// ============================================================================
module skyatl_datapath #(
    parameter int NUM_ATLASES  = skyatl_pkg::NUM_ATLASES_DEF,
    parameter int ATLAS_WIDTH  = skyatl_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = skyatl_pkg::ATLAS_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  skyatl_pkg::ctrl_cmd_t               cmd,
    output skyatl_pkg::ctrl_status_t            sts,
    input  logic [skyatl_pkg::CMD_W-1:0]        req_command,
    input  logic [skyatl_pkg::ATLAS_SEL_W-1:0]  req_atlas,
    input  logic [skyatl_pkg::RECT_W-1:0]       req_width,
    input  logic [skyatl_pkg::RECT_W-1:0]       req_height,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic                                res_placed,
    output logic [skyatl_pkg::POS_W-1:0]        res_x,
    output logic [skyatl_pkg::POS_W-1:0]        res_y,
    output logic [skyatl_pkg::REPORT_W-1:0]     res_report
);

    localparam int XW    = $clog2(ATLAS_WIDTH);
    localparam int HW    = $clog2(ATLAS_HEIGHT + 1);
    localparam int DEPTH = NUM_ATLASES * ATLAS_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((HW > skyatl_pkg::RECT_W) ? HW : skyatl_pkg::RECT_W) + 1;

    // Memories.
    logic [HW-1:0] height_mem [DEPTH];
    logic [HW-1:0] suffix_mem [ATLAS_WIDTH];

    // Latched request.
    logic [skyatl_pkg::CMD_W-1:0]       kind_reg;
    logic [skyatl_pkg::ATLAS_SEL_W-1:0] atlas_reg;
    logic [skyatl_pkg::RECT_W-1:0]      width_reg;
    logic [skyatl_pkg::RECT_W-1:0]      height_reg;
    logic [AW-1:0]                      base_reg;

    // Scan counters and the read pipeline stage.
    logic [XW-1:0] col_reg;
    logic [XW-1:0] phase_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          suf_v_reg;
    logic          pre_v_reg;
    logic [XW-1:0] col_d1_reg;
    logic [XW-1:0] phase_d1_reg;
    logic          blk_d1_reg;
    logic          cand_d1_reg;
    logic [HW-1:0] h_rd_reg;
    logic [HW-1:0] s_rd_reg;

    // Running maxima and the best candidate.
    logic [HW-1:0] suf_reg;
    logic [HW-1:0] pre_reg;
    logic [HW-1:0] best_reg;
    logic [XW-1:0] bestx_reg;
    logic          found_reg;

    logic [NUM_ATLASES-1:0] dirty_reg;

    // Response register.
    logic                            out_valid_reg;
    logic                            placed_reg;
    logic [skyatl_pkg::POS_W-1:0]    x_reg;
    logic [skyatl_pkg::POS_W-1:0]    y_reg;
    logic [skyatl_pkg::REPORT_W-1:0] report_reg;

    // Combinational helpers.
    logic [XW-1:0] wm1;
    logic          req_ok;
    logic [SW-1:0] new_top;
    logic          fit;
    logic [HW-1:0] new_height;
    logic [AW-1:0] col_addr;
    logic [XW-1:0] s_raddr;
    logic [HW-1:0] suf_new;
    logic [HW-1:0] pre_new;
    logic [HW-1:0] win_max;
    logic [XW-1:0] cand_x;
    logic          h_we;
    logic [AW-1:0] h_waddr;
    logic [HW-1:0] h_wdata;

    assign wm1 = XW'(width_reg - skyatl_pkg::RECT_W'(1));

    // Request checks: atlas in range, rectangle neither empty nor oversize.
    assign req_ok = (32'(atlas_reg) < NUM_ATLASES) && (width_reg != '0)
                 && (32'(width_reg) <= ATLAS_WIDTH) && (height_reg != '0)
                 && (32'(height_reg) <= ATLAS_HEIGHT);

    // Does the rectangle fit on the lowest floor found?
    assign new_top    = SW'(best_reg) + SW'(height_reg);
    assign fit        = found_reg && (new_top <= SW'(ATLAS_HEIGHT));
    assign new_height = HW'(new_top);

    assign col_addr = base_reg + AW'(col_reg);
    assign s_raddr  = col_reg - wm1;
    assign cand_x   = col_d1_reg - wm1;

    // Suffix maximum restarts at the rightmost column of each block.
    assign suf_new = (phase_d1_reg == '0) ? h_rd_reg
                   : ((h_rd_reg > suf_reg) ? h_rd_reg : suf_reg);

    // Prefix maximum restarts at the leftmost column of each block.
    assign pre_new = blk_d1_reg ? h_rd_reg
                   : ((h_rd_reg > pre_reg) ? h_rd_reg : pre_reg);

    // Window maximum joins the suffix of its left block and prefix of its right.
    assign win_max = (s_rd_reg > pre_new) ? s_rd_reg : pre_new;

    // Height memory write port serves the clearing sweep and the fill.
    assign h_we    = cmd.clr_step || cmd.fill_step;
    assign h_waddr = cmd.clr_step ? clr_addr_reg : col_addr;
    assign h_wdata = cmd.clr_step ? '0 : new_height;

    always_ff @(posedge aclk) begin
        if (h_we) begin
            height_mem[h_waddr] <= h_wdata;
        end
        h_rd_reg <= height_mem[col_addr];
    end

    always_ff @(posedge aclk) begin
        if (suf_v_reg) begin
            suffix_mem[col_d1_reg] <= suf_new;
        end
        s_rd_reg <= suffix_mem[s_raddr];
    end

    // Request latch.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg   <= req_command;
            atlas_reg  <= req_atlas;
            width_reg  <= req_width;
            height_reg <= req_height;
            base_reg   <= AW'(32'(req_atlas) * ATLAS_WIDTH);
        end
    end

    // Column and phase counters. The phase counter holds the column's offset
    // within its block during the scans and, during the fill, the columns left after the current one.
    always_ff @(posedge aclk) begin
        if (cmd.suf_start) begin
            col_reg   <= XW'(ATLAS_WIDTH - 1);
            phase_reg <= '0;
        end else if (cmd.suf_step) begin
            col_reg   <= col_reg - XW'(1);
            phase_reg <= (phase_reg == wm1) ? '0 : phase_reg + XW'(1);
        end else if (cmd.pre_start) begin
            col_reg   <= '0;
            phase_reg <= phase_d1_reg;
        end else if (cmd.pre_step) begin
            col_reg   <= col_reg + XW'(1);
            phase_reg <= (phase_reg == '0) ? wm1 : phase_reg - XW'(1);
        end else if (cmd.fill_start) begin
            col_reg   <= bestx_reg;
            phase_reg <= wm1;
        end else if (cmd.fill_step) begin
            col_reg   <= col_reg + XW'(1);
            phase_reg <= phase_reg - XW'(1);
        end
    end

    // Clearing sweep address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + AW'(1);
        end
    end

    // Read pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            suf_v_reg <= 1'b0;
            pre_v_reg <= 1'b0;
        end else begin
            suf_v_reg <= cmd.suf_step;
            pre_v_reg <= cmd.pre_step;
        end
    end

    // Per-column attributes travelling with the memory read.
    always_ff @(posedge aclk) begin
        if (cmd.suf_step || cmd.pre_step) begin
            col_d1_reg   <= col_reg;
            phase_d1_reg <= phase_reg;
            blk_d1_reg   <= (phase_reg == wm1) || (col_reg == '0);
            cand_d1_reg  <= (col_reg >= wm1);
        end
    end

    // Running maxima.
    always_ff @(posedge aclk) begin
        if (suf_v_reg) begin
            suf_reg <= suf_new;
        end
        if (pre_v_reg) begin
            pre_reg <= pre_new;
        end
    end

    // Lowest floor so far; a strict compare keeps the leftmost of equal floors.
    always_ff @(posedge aclk) begin
        if (cmd.pre_start) begin
            best_reg <= HW'(ATLAS_HEIGHT);
        end else if (pre_v_reg && cand_d1_reg && (win_max < best_reg)) begin
            best_reg  <= win_max;
            bestx_reg <= cand_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.latch) begin
            found_reg <= 1'b0;
        end else if (pre_v_reg && cand_d1_reg && (win_max < best_reg)) begin
            found_reg <= 1'b1;
        end
    end

    // Dirty flags are updated as the response is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= '0;
        end else if (cmd.load_result) begin
            case (kind_reg)
                skyatl_pkg::CMD_ALLOC: begin
                    if (fit) begin
                        dirty_reg <= dirty_reg | (NUM_ATLASES'(1) << atlas_reg);
                    end
                end
                skyatl_pkg::CMD_CLEAR: begin
                    dirty_reg <= '0;
                end
                skyatl_pkg::CMD_DIRTY: begin
                    dirty_reg <= '0;
                end
                default: begin
                    dirty_reg <= dirty_reg;
                end
            endcase
        end
    end

    // Response payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            placed_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            report_reg <= '0;
            case (kind_reg)
                skyatl_pkg::CMD_ALLOC: begin
                    if (fit) begin
                        placed_reg <= 1'b1;
                        x_reg      <= skyatl_pkg::POS_W'(bestx_reg);
                        y_reg      <= skyatl_pkg::POS_W'(best_reg);
                    end
                end
                skyatl_pkg::CMD_CLEAR: begin
                    placed_reg <= 1'b1;
                end
                skyatl_pkg::CMD_DIRTY: begin
                    placed_reg <= 1'b1;
                    report_reg <= skyatl_pkg::REPORT_W'(dirty_reg);
                end
                default: begin
                    placed_reg <= 1'b0;
                end
            endcase
        end
    end

    // Response valid; a waiting response is held until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status towards the controller.
    always_comb begin
        sts           = '0;
        sts.kind      = kind_reg;
        sts.req_ok    = req_ok;
        sts.col_zero  = (col_reg == '0);
        sts.col_end   = (col_reg == XW'(ATLAS_WIDTH - 1));
        sts.fill_last = (phase_reg == '0);
        sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
        sts.fit       = fit;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid   = out_valid_reg;
    assign res_placed = placed_reg;
    assign res_x      = x_reg;
    assign res_y      = y_reg;
    assign res_report = report_reg;

    // Columns are only raised for a rectangle that fits.
    a_fill_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_step |-> fit)
        else $error("fill without a fitting floor");

    // A recorded floor always lies below the atlas top.
    a_found_below: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (32'(best_reg) < ATLAS_HEIGHT))
        else $error("best floor at or above atlas height");

    // The block offset stays inside the rectangle width while scanning and filling.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.suf_step || cmd.pre_step || cmd.fill_step) |-> (phase_reg <= wm1))
        else $error("phase counter beyond rectangle width");

    // A chosen span never runs past the right edge of the atlas.
    a_span_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> ((32'(bestx_reg) + 32'(wm1)) < ATLAS_WIDTH))
        else $error("placed span beyond atlas width");

endmodule
